/* rtl/mesh_radio_frame_field_parser_core_defines.svh */
// Assertion macros shared by the frame parser modules.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef MESH_RADIO_FRAME_FIELD_PARSER_CORE_DEFINES_SVH
`define MESH_RADIO_FRAME_FIELD_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MRFFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define MRFFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mrffp_pkg.sv */
`default_nettype none

package mrffp_pkg;

  // Record kinds
  localparam logic [1:0] KIND_HOP     = 2'd0;
  localparam logic [1:0] KIND_TAG     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Byte tags
  localparam logic [4:0] TAG_PUSH      = 5'd0;
  localparam logic [4:0] TAG_KEY       = 5'd1;
  localparam logic [4:0] TAG_TIME      = 5'd2;
  localparam logic [4:0] TAG_SIG       = 5'd3;
  localparam logic [4:0] TAG_FLAGS     = 5'd4;
  localparam logic [4:0] TAG_LAT       = 5'd5;
  localparam logic [4:0] TAG_LON       = 5'd6;
  localparam logic [4:0] TAG_BLE       = 5'd7;
  localparam logic [4:0] TAG_SHORTCUT  = 5'd8;
  localparam logic [4:0] TAG_NAME      = 5'd9;
  localparam logic [4:0] TAG_DST       = 5'd10;
  localparam logic [4:0] TAG_SRC       = 5'd11;
  localparam logic [4:0] TAG_REQMAC    = 5'd12;
  localparam logic [4:0] TAG_REQCIPHER = 5'd13;
  localparam logic [4:0] TAG_OTHER     = 5'd14;
  localparam logic [4:0] TAG_CHAN      = 5'd15;
  localparam logic [4:0] TAG_GRPMAC    = 5'd16;
  localparam logic [4:0] TAG_GRPCIPHER = 5'd17;

  // Frame status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_SHORT      = 4'd1;
  localparam logic [3:0] ST_RESERVED   = 4'd2;
  localparam logic [3:0] ST_PATH_CUT   = 4'd3;
  localparam logic [3:0] ST_ADV_SHORT  = 4'd4;
  localparam logic [3:0] ST_GPS        = 4'd5;
  localparam logic [3:0] ST_BLE        = 4'd6;
  localparam logic [3:0] ST_SHORTCUT   = 4'd7;
  localparam logic [3:0] ST_REQ_SHORT  = 4'd8;
  localparam logic [3:0] ST_GRP_SHORT  = 4'd9;

  // One queue word: an optional hop or tag record, then an optional summary
  typedef struct packed {
    logic              rec_v;
    logic [1:0]        rec_kind;
    logic [23:0]       rec_hash;
    logic [7:0]        rec_byte;
    logic [4:0]        rec_tag;
    logic              sum_v;
    logic [1:0]        route_type;
    logic [3:0]        payload_type;
    logic [1:0]        payload_version;
    logic signed [7:0] snr;
    logic signed [7:0] rssi;
    logic [5:0]        hop_count;
    logic [3:0]        status;
  } entry_t;

  // Queue handshake toward the front and the back
  typedef struct packed {
    logic full;
    logic head_valid;
  } q_status_t;

endpackage

`default_nettype wire

/* rtl/mrffp_front.sv */
`default_nettype none

`include "mesh_radio_frame_field_parser_core_defines.svh"

module mrffp_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_frame_end,
  output logic                 push,
  output mrffp_pkg::entry_t    push_word
);

  // Parse phases
  localparam logic [3:0] PH_PUSH      = 4'd0;
  localparam logic [3:0] PH_SNR       = 4'd1;
  localparam logic [3:0] PH_RSSI      = 4'd2;
  localparam logic [3:0] PH_HDR       = 4'd3;
  localparam logic [3:0] PH_META      = 4'd4;
  localparam logic [3:0] PH_PATH      = 4'd5;
  localparam logic [3:0] PH_ADV_FIXED = 4'd6;
  localparam logic [3:0] PH_ADV_FLAGS = 4'd7;
  localparam logic [3:0] PH_GPS       = 4'd8;
  localparam logic [3:0] PH_BLE       = 4'd9;
  localparam logic [3:0] PH_SC        = 4'd10;
  localparam logic [3:0] PH_ADV_REST  = 4'd11;
  localparam logic [3:0] PH_REQ       = 4'd12;
  localparam logic [3:0] PH_GRP       = 4'd13;
  localparam logic [3:0] PH_OTHER     = 4'd14;
  localparam logic [3:0] PH_ERR       = 4'd15;

  localparam logic [3:0] PT_REQ = 4'd0;
  localparam logic [3:0] PT_ADV = 4'd4;
  localparam logic [3:0] PT_GRP = 4'd5;

  localparam logic [6:0] ADV_FIXED_LEN = 7'd100;

  // Pick the payload layout from the header's payload type
  function automatic logic [3:0] payload_phase(input logic [7:0] hdr);
    logic [3:0] t;
    t = hdr[5:2];
    if (t == PT_ADV)      payload_phase = PH_ADV_FIXED;
    else if (t == PT_REQ) payload_phase = PH_REQ;
    else if (t == PT_GRP) payload_phase = PH_GRP;
    else                  payload_phase = PH_OTHER;
  endfunction

  // Pick the next advert part still owed, starting at option position from
  function automatic logic [3:0] advert_phase(input logic [1:0] from, input logic [3:0] opt);
    if (from == 2'd0 && opt[0])       advert_phase = PH_GPS;
    else if (from <= 2'd1 && opt[1])  advert_phase = PH_BLE;
    else if (from <= 2'd2 && opt[2])  advert_phase = PH_SC;
    else                              advert_phase = PH_ADV_REST;
  endfunction

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  fld_cnt_r, fld_cnt_nxt;
  logic [5:0]  hops_rem_r, hops_rem_nxt;
  logic [1:0]  hop_idx_r, hop_idx_nxt;
  logic [23:0] hop_acc_r, hop_acc_nxt;
  logic [1:0]  hop_size_r, hop_size_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic [7:0]  snr_r, snr_nxt;
  logic [7:0]  rssi_r, rssi_nxt;
  logic [5:0]  plen_r, plen_nxt;
  logic [6:0]  pay_cnt_r, pay_cnt_nxt;
  logic [3:0]  opt_r, opt_nxt;
  logic [3:0]  err_r, err_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;

  logic        rec_v;
  logic [1:0]  rec_kind;
  logic [23:0] rec_hash;
  logic [4:0]  rec_tag;
  logic [3:0]  status;
  logic [6:0]  idx;
  logic [23:0] acc_shift;
  logic [5:0]  hops_dec;
  logic [3:0]  fld_inc;

  assign idx       = pay_cnt_r;
  assign acc_shift = {hop_acc_r[15:0], in_byte};
  assign hops_dec  = hops_rem_r - 6'd1;
  assign fld_inc   = fld_cnt_r + 4'd1;

  // Advance the parse state by one byte and classify it
  always_comb begin
    phase_nxt    = phase_r;
    fld_cnt_nxt  = fld_cnt_r;
    hops_rem_nxt = hops_rem_r;
    hop_idx_nxt  = hop_idx_r;
    hop_acc_nxt  = hop_acc_r;
    hop_size_nxt = hop_size_r;
    hdr_nxt      = hdr_r;
    snr_nxt      = snr_r;
    rssi_nxt     = rssi_r;
    plen_nxt     = plen_r;
    pay_cnt_nxt  = pay_cnt_r;
    opt_nxt      = opt_r;
    err_nxt      = err_r;
    fcnt_nxt     = fcnt_r;
    rec_v        = 1'b0;
    rec_kind     = mrffp_pkg::KIND_TAG;
    rec_hash     = '0;
    rec_tag      = mrffp_pkg::TAG_PUSH;

    if (err_r == mrffp_pkg::ST_OK) begin
      if (fcnt_r < 3'd5) begin
        fcnt_nxt = fcnt_r + 3'd1;
      end
      if (phase_r inside {[PH_ADV_FIXED:PH_OTHER]} && pay_cnt_r < ADV_FIXED_LEN) begin
        pay_cnt_nxt = pay_cnt_r + 7'd1;
      end

      case (phase_r)
        PH_PUSH: begin
          rec_v     = 1'b1;
          rec_tag   = mrffp_pkg::TAG_PUSH;
          phase_nxt = PH_SNR;
        end
        PH_SNR: begin
          snr_nxt   = in_byte;
          phase_nxt = PH_RSSI;
        end
        PH_RSSI: begin
          rssi_nxt  = in_byte;
          phase_nxt = PH_HDR;
        end
        PH_HDR: begin
          hdr_nxt   = in_byte;
          phase_nxt = PH_META;
        end
        PH_META: begin
          plen_nxt     = in_byte[5:0];
          hop_size_nxt = in_byte[7:6];
          if (in_byte[7:6] == 2'd3) begin
            err_nxt   = mrffp_pkg::ST_RESERVED;
            phase_nxt = PH_ERR;
          end else if (in_byte[5:0] == 6'd0) begin
            phase_nxt = payload_phase(hdr_r);
          end else begin
            hops_rem_nxt = in_byte[5:0];
            hop_idx_nxt  = 2'd0;
            hop_acc_nxt  = '0;
            phase_nxt    = PH_PATH;
          end
        end
        PH_PATH: begin
          hop_acc_nxt = acc_shift;
          if (hop_idx_r >= hop_size_r) begin
            rec_v        = 1'b1;
            rec_kind     = mrffp_pkg::KIND_HOP;
            rec_hash     = acc_shift;
            hop_acc_nxt  = '0;
            hop_idx_nxt  = 2'd0;
            hops_rem_nxt = hops_dec;
            if (hops_dec == 6'd0) begin
              phase_nxt = payload_phase(hdr_r);
            end
          end else begin
            hop_idx_nxt = hop_idx_r + 2'd1;
          end
        end
        PH_ADV_FIXED: begin
          rec_v = 1'b1;
          if (idx < 7'd32)      rec_tag = mrffp_pkg::TAG_KEY;
          else if (idx < 7'd36) rec_tag = mrffp_pkg::TAG_TIME;
          else                  rec_tag = mrffp_pkg::TAG_SIG;
          if (idx >= 7'd99) begin
            phase_nxt = PH_ADV_FLAGS;
          end
        end
        PH_ADV_FLAGS: begin
          rec_v       = 1'b1;
          rec_tag     = mrffp_pkg::TAG_FLAGS;
          opt_nxt     = in_byte[7:4];
          fld_cnt_nxt = 4'd0;
          phase_nxt   = advert_phase(2'd0, in_byte[7:4]);
        end
        PH_GPS: begin
          rec_v       = 1'b1;
          rec_tag     = (fld_cnt_r < 4'd4) ? mrffp_pkg::TAG_LAT : mrffp_pkg::TAG_LON;
          fld_cnt_nxt = fld_inc;
          if (fld_inc >= 4'd8) begin
            fld_cnt_nxt = 4'd0;
            phase_nxt   = advert_phase(2'd1, opt_r);
          end
        end
        PH_BLE: begin
          rec_v       = 1'b1;
          rec_tag     = mrffp_pkg::TAG_BLE;
          fld_cnt_nxt = fld_inc;
          if (fld_inc >= 4'd2) begin
            fld_cnt_nxt = 4'd0;
            phase_nxt   = advert_phase(2'd2, opt_r);
          end
        end
        PH_SC: begin
          rec_v       = 1'b1;
          rec_tag     = mrffp_pkg::TAG_SHORTCUT;
          fld_cnt_nxt = fld_inc;
          if (fld_inc >= 4'd2) begin
            fld_cnt_nxt = 4'd0;
            phase_nxt   = advert_phase(2'd3, opt_r);
          end
        end
        PH_ADV_REST: begin
          rec_v   = 1'b1;
          rec_tag = opt_r[3] ? mrffp_pkg::TAG_NAME : mrffp_pkg::TAG_OTHER;
        end
        PH_REQ: begin
          rec_v = 1'b1;
          if (idx == 7'd0)      rec_tag = mrffp_pkg::TAG_DST;
          else if (idx == 7'd1) rec_tag = mrffp_pkg::TAG_SRC;
          else if (idx < 7'd4)  rec_tag = mrffp_pkg::TAG_REQMAC;
          else                  rec_tag = mrffp_pkg::TAG_REQCIPHER;
        end
        PH_GRP: begin
          rec_v = 1'b1;
          if (idx == 7'd0)     rec_tag = mrffp_pkg::TAG_CHAN;
          else if (idx < 7'd3) rec_tag = mrffp_pkg::TAG_GRPMAC;
          else                 rec_tag = mrffp_pkg::TAG_GRPCIPHER;
        end
        PH_OTHER: begin
          rec_v   = 1'b1;
          rec_tag = mrffp_pkg::TAG_OTHER;
        end
        default: begin
        end
      endcase
    end
  end

  // Judge the frame from the state left after this byte
  always_comb begin
    status = mrffp_pkg::ST_OK;
    if (err_nxt != mrffp_pkg::ST_OK) begin
      status = err_nxt;
    end else if (fcnt_nxt < 3'd5) begin
      status = mrffp_pkg::ST_SHORT;
    end else if (phase_nxt == PH_PATH) begin
      status = mrffp_pkg::ST_PATH_CUT;
    end else if (hdr_nxt[5:2] == PT_ADV) begin
      if (pay_cnt_nxt < ADV_FIXED_LEN)  status = mrffp_pkg::ST_ADV_SHORT;
      else if (phase_nxt == PH_GPS)     status = mrffp_pkg::ST_GPS;
      else if (phase_nxt == PH_BLE)     status = mrffp_pkg::ST_BLE;
      else if (phase_nxt == PH_SC)      status = mrffp_pkg::ST_SHORTCUT;
    end else if (hdr_nxt[5:2] == PT_REQ) begin
      if (pay_cnt_nxt < 7'd4) status = mrffp_pkg::ST_REQ_SHORT;
    end else if (hdr_nxt[5:2] == PT_GRP) begin
      if (pay_cnt_nxt < 7'd3) status = mrffp_pkg::ST_GRP_SHORT;
    end
  end

  // Build the queue word
  always_comb begin
    push_word                 = '0;
    push_word.rec_v           = rec_v;
    push_word.rec_kind        = rec_kind;
    push_word.rec_hash        = rec_hash;
    push_word.rec_byte        = in_byte;
    push_word.rec_tag         = rec_tag;
    push_word.sum_v           = in_frame_end;
    push_word.route_type      = hdr_nxt[1:0];
    push_word.payload_type    = hdr_nxt[5:2];
    push_word.payload_version = hdr_nxt[7:6];
    push_word.snr             = snr_nxt;
    push_word.rssi            = rssi_nxt;
    push_word.hop_count       = plen_nxt;
    push_word.status          = status;
  end

  assign push = accept && (rec_v || in_frame_end);

  // Update parse state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_frame_end)) begin
      phase_r    <= PH_PUSH;
      fld_cnt_r  <= '0;
      hops_rem_r <= '0;
      hop_idx_r  <= '0;
      hop_acc_r  <= '0;
      hop_size_r <= '0;
      hdr_r      <= '0;
      snr_r      <= '0;
      rssi_r     <= '0;
      plen_r     <= '0;
      pay_cnt_r  <= '0;
      opt_r      <= '0;
      err_r      <= '0;
      fcnt_r     <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      fld_cnt_r  <= fld_cnt_nxt;
      hops_rem_r <= hops_rem_nxt;
      hop_idx_r  <= hop_idx_nxt;
      hop_acc_r  <= hop_acc_nxt;
      hop_size_r <= hop_size_nxt;
      hdr_r      <= hdr_nxt;
      snr_r      <= snr_nxt;
      rssi_r     <= rssi_nxt;
      plen_r     <= plen_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
      opt_r      <= opt_nxt;
      err_r      <= err_nxt;
      fcnt_r     <= fcnt_nxt;
    end
  end

  // Error phase and the reserved-size error travel together
  `MRFFP_ASSERT_NOW(a_err_phase, phase_r == PH_ERR, err_r == mrffp_pkg::ST_RESERVED, "error phase without error code")
  // Path phase always has hops left to take
  `MRFFP_ASSERT_NOW(a_path_hops, phase_r == PH_PATH, hops_rem_r != 6'd0, "path phase with no hops left")
  // Byte counters never pass their saturation points
  `MRFFP_ASSERT_NOW(a_sat, 1'b1, fcnt_r <= 3'd5 && pay_cnt_r <= ADV_FIXED_LEN, "counter past limit")

endmodule

`default_nettype wire

/* rtl/mrffp_queue.sv */
`default_nettype none

`include "mesh_radio_frame_field_parser_core_defines.svh"

module mrffp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mrffp_pkg::entry_t push_word,
  input  wire logic            pop,
  output mrffp_pkg::q_status_t q_stat,
  output mrffp_pkg::entry_t    head_word
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  mrffp_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign q_stat.full       = (cnt_r == CW'(DEPTH));
  assign q_stat.head_valid = (cnt_r != '0);
  assign head_word         = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + CW'(1);
    else if (!push && pop) cnt_nxt = cnt_r - CW'(1);
  end

  // Store words; no reset needed on the payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  `MRFFP_ASSERT_NOW(a_no_overflow, push, !q_stat.full, "push into full queue")
  `MRFFP_ASSERT_NOW(a_no_underflow, pop, q_stat.head_valid, "pop from empty queue")
  `MRFFP_ASSERT_NOW(a_word_has_record, q_stat.head_valid, head_word.rec_v || head_word.sum_v, "queued word carries no record")

endmodule

`default_nettype wire

/* rtl/mrffp_back.sv */
`default_nettype none

`include "mesh_radio_frame_field_parser_core_defines.svh"

module mrffp_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mrffp_pkg::q_status_t q_stat,
  input  wire mrffp_pkg::entry_t    head_word,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_record_kind,
  output logic [23:0]               out_hop_hash,
  output logic [7:0]                out_payload_byte,
  output logic [4:0]                out_byte_tag,
  output logic [1:0]                out_route_type,
  output logic [3:0]                out_payload_type,
  output logic [1:0]                out_payload_version,
  output logic signed [7:0]         out_snr_quarter_db,
  output logic signed [7:0]         out_rssi_dbm,
  output logic [5:0]                out_hop_count,
  output logic [3:0]                out_frame_status,
  output logic                      out_run_last
);

  logic        valid_r;
  logic        sub_r, sub_nxt;
  logic        load;
  logic        take_rec;
  logic [1:0]  kind_r, kind_nxt;
  logic [23:0] hash_r, hash_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [4:0]  tag_r, tag_nxt;
  logic [1:0]  route_r, route_nxt;
  logic [3:0]  ptype_r, ptype_nxt;
  logic [1:0]  ver_r, ver_nxt;
  logic [7:0]  snr_r, snr_nxt;
  logic [7:0]  rssi_r, rssi_nxt;
  logic [5:0]  hops_r, hops_nxt;
  logic [3:0]  status_r, status_nxt;
  logic        last_r, last_nxt;

  // Load the output register when it is free or being taken
  assign load     = q_stat.head_valid && (!valid_r || !out_stall);
  assign take_rec = head_word.rec_v && !sub_r;
  assign pop      = load && !(take_rec && head_word.sum_v);

  // Select the record from the head word
  always_comb begin
    kind_nxt   = mrffp_pkg::KIND_SUMMARY;
    hash_nxt   = '0;
    byte_nxt   = '0;
    tag_nxt    = '0;
    route_nxt  = head_word.route_type;
    ptype_nxt  = head_word.payload_type;
    ver_nxt    = head_word.payload_version;
    snr_nxt    = head_word.snr;
    rssi_nxt   = head_word.rssi;
    hops_nxt   = head_word.hop_count;
    status_nxt = head_word.status;
    last_nxt   = 1'b1;
    sub_nxt    = 1'b0;
    if (take_rec) begin
      kind_nxt   = head_word.rec_kind;
      route_nxt  = '0;
      ptype_nxt  = '0;
      ver_nxt    = '0;
      snr_nxt    = '0;
      rssi_nxt   = '0;
      hops_nxt   = '0;
      status_nxt = '0;
      last_nxt   = !head_word.sum_v;
      sub_nxt    = head_word.sum_v;
      if (head_word.rec_kind == mrffp_pkg::KIND_HOP) begin
        hash_nxt = head_word.rec_hash;
      end else begin
        byte_nxt = head_word.rec_byte;
        tag_nxt  = head_word.rec_tag;
      end
    end
  end

  // Hold the word while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        sub_r   <= sub_nxt;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= kind_nxt;
      hash_r   <= hash_nxt;
      byte_r   <= byte_nxt;
      tag_r    <= tag_nxt;
      route_r  <= route_nxt;
      ptype_r  <= ptype_nxt;
      ver_r    <= ver_nxt;
      snr_r    <= snr_nxt;
      rssi_r   <= rssi_nxt;
      hops_r   <= hops_nxt;
      status_r <= status_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid           = valid_r;
  assign out_record_kind     = kind_r;
  assign out_hop_hash        = hash_r;
  assign out_payload_byte    = byte_r;
  assign out_byte_tag        = tag_r;
  assign out_route_type      = route_r;
  assign out_payload_type    = ptype_r;
  assign out_payload_version = ver_r;
  assign out_snr_quarter_db  = snr_r;
  assign out_rssi_dbm        = rssi_r;
  assign out_hop_count       = hops_r;
  assign out_frame_status    = status_r;
  assign out_run_last        = last_r;

  // A summary always closes the byte's records
  `MRFFP_ASSERT_NOW(a_sum_last, valid_r && kind_r == mrffp_pkg::KIND_SUMMARY, last_r, "summary not last")
  // A held second record means the head word still waits for its summary
  `MRFFP_ASSERT_NOW(a_sub_head, sub_r, q_stat.head_valid && head_word.sum_v, "pending summary lost")
  // After a first record with a summary behind it, the summary comes next
  `MRFFP_ASSERT_NEXT(a_sub_order, load && take_rec && head_word.sum_v, sub_r, "summary skipped")

endmodule

`default_nettype wire

/* rtl/mesh_radio_frame_field_parser_core.sv */
// Mesh radio log frame field parser.
// Input channel: one raw frame byte per word (in_byte), with in_frame_end high
// on the frame's final byte. A word is taken when in_valid is high and in_stall
// low. Output channel: one record per word (hop hash, tagged payload byte or
// frame summary), taken when out_valid is high and out_stall low; out_run_last
// marks the last record caused by one input byte.
// Throughput: one input byte per cycle while in_stall is low. Most bytes cause
// zero or one record; the final byte can cause two (its own record and the
// summary), which leave as two output words. The front parser runs one byte
// per cycle into a queue of QUEUE_DEPTH words; the back drains one record per
// cycle into an output register unless out_stall holds a valid word there.
// The byte's word is written into the queue when the byte is accepted; the
// output register then loads it from the queue head when free or being taken.
// Reset (synchronous, rst_n low): parser returns to expecting a push code,
// queue empties, out_valid drops. No clearing pass.
// Receiver stall: the output register holds its word; the queue fills and then
// in_stall rises until space frees.
`default_nettype none

module mesh_radio_frame_field_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_frame_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_record_kind,
  output logic [23:0]      out_hop_hash,
  output logic [7:0]       out_payload_byte,
  output logic [4:0]       out_byte_tag,
  output logic [1:0]       out_route_type,
  output logic [3:0]       out_payload_type,
  output logic [1:0]       out_payload_version,
  output logic signed [7:0] out_snr_quarter_db,
  output logic signed [7:0] out_rssi_dbm,
  output logic [5:0]       out_hop_count,
  output logic [3:0]       out_frame_status,
  output logic             out_run_last
);

  logic                 accept;
  logic                 push;
  logic                 pop;
  mrffp_pkg::entry_t    push_word;
  mrffp_pkg::entry_t    head_word;
  mrffp_pkg::q_status_t q_stat;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  mrffp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_frame_end (in_frame_end),
    .push         (push),
    .push_word    (push_word)
  );

  mrffp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .q_stat    (q_stat),
    .head_word (head_word)
  );

  mrffp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .head_word           (head_word),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_record_kind     (out_record_kind),
    .out_hop_hash        (out_hop_hash),
    .out_payload_byte    (out_payload_byte),
    .out_byte_tag        (out_byte_tag),
    .out_route_type      (out_route_type),
    .out_payload_type    (out_payload_type),
    .out_payload_version (out_payload_version),
    .out_snr_quarter_db  (out_snr_quarter_db),
    .out_rssi_dbm        (out_rssi_dbm),
    .out_hop_count       (out_hop_count),
    .out_frame_status    (out_frame_status),
    .out_run_last        (out_run_last)
  );

endmodule

`default_nettype wire
